/* rtl/core/sbd_pkg.sv */
// ============================================================================
// sbd_pkg: shared types and constants of the supersample box downsampler
// Holds the configuration register map, fixed field widths and the tag
// that travels with each finished block sum from the front to the back.
// ============================================================================
package sbd_pkg;

    localparam int SUM_W        = 22;
    localparam int AVG_W        = 16;
    localparam int OUT_DATA_W   = 3 * AVG_W;
    localparam int FX_W         = 5;
    localparam int FSQ_W        = 2 * FX_W;
    localparam int DIV_W        = 9;
    localparam int ROW_W        = 10;
    localparam int HT_W         = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int FACTOR_W     = 4;
    localparam int WIDTH_W      = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [WIDTH_W-1:0]  HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [WIDTH_W-1:0]  out_width;
        logic [WIDTH_W-1:0]  out_height;
    } sbd_cfg_t;

    typedef struct packed {
        logic [DIV_W-1:0] divisor;
        logic             row_end;
        logic             frame_end;
    } sbd_tag_t;

endpackage

/* rtl/core/sbd_queue.sv */
// ============================================================================
// sbd_queue: small first-in first-out queue
// Decouples the sample front end from the dividing back end.
// ============================================================================
module sbd_queue
    import sbd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid,
    output logic [CNT_W-1:0] free
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign valid = (count_reg != '0);
    assign free  = CNT_W'(DEPTH) - count_reg;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/core/sbd_front.sv */
// ============================================================================
// sbd_front: sample front end of the box downsampler
// Tracks the position inside the block and frame, accumulates per-column
// block sums in a memory and hands each finished block sum to the queue.
// ============================================================================
module sbd_front
    import sbd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_FACTOR    = 8,
    parameter int SAMPLE_BITS   = 16,
    localparam int IN_W    = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int STORE_W = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbd_cfg_t               cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,
    input  logic [QCNT_W-1:0]      q_free,
    output logic                   q_push,
    output logic [3*STORE_W-1:0]   q_sums,
    output sbd_tag_t               q_tag
);

    localparam int CB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int COL_W = $clog2(MAX_OUT_WIDTH);
    localparam int WX_W  = ($clog2(MAX_OUT_WIDTH + 1) > WIDTH_W) ?
                           $clog2(MAX_OUT_WIDTH + 1) : WIDTH_W;

    logic [FX_W-1:0]  f_raw, f_eff;
    logic [FSQ_W-1:0] f_sq;
    logic [WX_W-1:0]  w_raw, w_eff;
    logic [HT_W-1:0]  h_eff;

    logic [CB_W-1:0]  cib_reg, cib_next;
    logic [CB_W-1:0]  rib_reg, rib_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic accept;
    logic last_sub_col, last_sub_row, last_col, last_row;

    logic                     s1_valid_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic                     s1_first_reg;
    logic                     s1_emit_reg;
    sbd_tag_t                 s1_tag_reg;
    logic [3*SAMPLE_BITS-1:0] s1_smp_reg;
    logic [3*STORE_W-1:0]     s1_sums;

    logic [3*STORE_W-1:0] sum_mem [MAX_OUT_WIDTH];
    logic [3*STORE_W-1:0] rd_reg;
    logic [3*STORE_W-1:0] fwd_sum_reg;
    logic                 fwd_hit_reg;

    always_comb
    begin
        f_raw = FX_W'(cfg.factor);
        if (f_raw == '0)
        begin
            f_eff = FX_W'(1);
        end
        else if (f_raw > FX_W'(MAX_FACTOR))
        begin
            f_eff = FX_W'(MAX_FACTOR);
        end
        else
        begin
            f_eff = f_raw;
        end

        w_raw = WX_W'(cfg.out_width);
        if (w_raw == '0)
        begin
            w_eff = WX_W'(1);
        end
        else if (w_raw > WX_W'(MAX_OUT_WIDTH))
        begin
            w_eff = WX_W'(MAX_OUT_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end

        if (cfg.out_height == '0)
        begin
            h_eff = HT_W'(1);
        end
        else if (cfg.out_height > HT_W'(HEIGHT_LIMIT))
        begin
            h_eff = HT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = cfg.out_height;
        end

        f_sq = FSQ_W'(f_eff) * FSQ_W'(f_eff);
    end

    assign last_sub_col = (FX_W'(cib_reg) + FX_W'(1)) >= f_eff;
    assign last_sub_row = (FX_W'(rib_reg) + FX_W'(1)) >= f_eff;
    assign last_col     = (WX_W'(col_reg) + WX_W'(1)) >= w_eff;
    assign last_row     = (HT_W'(row_reg) + HT_W'(1)) >= h_eff;

    // One slot is held back for the item that may be in the accumulate stage.
    assign s_tready = q_free > QCNT_W'(s1_valid_reg);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cib_next = cib_reg;
        rib_next = rib_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_sub_col)
            begin
                cib_next = '0;
                if (last_col)
                begin
                    col_next = '0;
                    if (last_sub_row)
                    begin
                        rib_next = '0;
                        row_next = last_row ? '0 : row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        rib_next = rib_reg + CB_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            else
            begin
                cib_next = cib_reg + CB_W'(1);
            end
        end
    end

    // The write of the item ahead is not yet visible to a read in the same
    // cycle, so a hit on its column takes the freshly computed sum instead.
    always_comb
    begin
        logic [3*STORE_W-1:0]   base;
        logic [SAMPLE_BITS-1:0] smp;
        logic [SUM_W-1:0]       acc;
        base = fwd_hit_reg ? fwd_sum_reg : rd_reg;
        s1_sums = '0;
        for (int i = 0; i < 3; i++)
        begin
            smp = s1_smp_reg[i*SAMPLE_BITS +: SAMPLE_BITS];
            acc = SUM_W'(base[i*STORE_W +: STORE_W]) + SUM_W'(smp);
            s1_sums[i*STORE_W +: STORE_W] = s1_first_reg ? STORE_W'(smp) : STORE_W'(acc);
        end
    end

    assign q_push = s1_valid_reg && s1_emit_reg;
    assign q_sums = s1_sums;
    assign q_tag  = s1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cib_reg      <= '0;
            rib_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            cib_reg      <= cib_next;
            rib_reg      <= rib_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg           <= col_reg;
            s1_first_reg         <= (cib_reg == '0) && (rib_reg == '0);
            s1_emit_reg          <= last_sub_col && last_sub_row;
            s1_tag_reg.divisor   <= DIV_W'(f_sq);
            s1_tag_reg.row_end   <= last_col;
            s1_tag_reg.frame_end <= last_col && last_row;
            s1_smp_reg           <= s_tdata[3*SAMPLE_BITS-1:0];
        end
        fwd_sum_reg <= s1_sums;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            sum_mem[s1_col_reg] <= s1_sums;
        end
        rd_reg <= sum_mem[col_reg];
    end

endmodule

/* rtl/core/sbd_back.sv */
// ============================================================================
// sbd_back: dividing back end of the box downsampler
// Divides each block sum by factor squared with a bit-serial restoring
// divider, saturates the averages and holds them in the output register.
// ============================================================================
module sbd_back
    import sbd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    localparam int STORE_W = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [3*STORE_W-1:0]  q_sums,
    input  sbd_tag_t              q_tag,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    localparam int STEP_W = $clog2(STORE_W);
    localparam logic [STORE_W-1:0] MAXV = STORE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STORE_W-1:0] quo_reg [3];
    logic [STORE_W-1:0] quo_next [3];
    logic [DIV_W-1:0]   rem_reg [3];
    logic [DIV_W-1:0]   rem_next [3];
    sbd_tag_t          tag_reg, tag_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_user_reg, out_user_next;
    logic                  load_out;

    always_comb
    begin
        logic [DIV_W:0]     rs;
        logic               ge;
        logic [STORE_W-1:0] sat;
        rs             = '0;
        ge             = 1'b0;
        sat            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        tag_next       = tag_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        for (int i = 0; i < 3; i++)
        begin
            quo_next[i] = quo_reg[i];
            rem_next[i] = rem_reg[i];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    tag_next  = q_tag;
                    step_next = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        quo_next[i] = q_sums[i*STORE_W +: STORE_W];
                        rem_next[i] = '0;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rs = {rem_reg[i], quo_reg[i][STORE_W-1]};
                    ge = rs >= {1'b0, tag_reg.divisor};
                    rem_next[i] = ge ? DIV_W'(rs - {1'b0, tag_reg.divisor}) : DIV_W'(rs);
                    quo_next[i] = {quo_reg[i][STORE_W-2:0], ge};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STORE_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        sat = ((quo_reg[i] >> SAMPLE_BITS) != '0) ? MAXV : quo_reg[i];
                        out_data_next[i*AVG_W +: AVG_W] = AVG_W'(sat);
                    end
                    out_last_next = tag_reg.row_end;
                    out_user_next = tag_reg.frame_end;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !m_tready);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo_reg[i] <= quo_next[i];
            rem_reg[i] <= rem_next[i];
        end
        tag_reg      <= tag_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

endmodule

/* rtl/core/supersample_box_downsampler.sv */
// ============================================================================
// supersample_box_downsampler: integer box filter for supersampled frames
// Averages each factor-by-factor block of RGB samples into one pixel.
// ============================================================================
// Samples enter in raster order, one per clock while the block queue has
// room. Per-column partial sums live in a memory of MAX_OUT_WIDTH entries
// that needs no clearing: each block writes its entry fresh on its first
// sample. Each output pixel then passes through the bit-serial divider of
// the back end, which takes no new block sum from the queue until it has
// loaded the current averages into its output register, so the input is
// held back whenever the queue fills. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module supersample_box_downsampler
    import sbd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_FACTOR    = 8,
    parameter int SAMPLE_BITS   = 16,
    localparam int IN_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: sample_red, sample_green, sample_blue, zero padding
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    // m_tdata: avg_red, avg_green, avg_blue
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // m_tuser: frame_end
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_W = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
    localparam int Q_W     = 3 * STORE_W + $bits(sbd_tag_t);

    sbd_cfg_t cfg_reg, cfg_next;

    logic                 push, pop, q_valid;
    logic [QCNT_W-1:0]    q_free;
    logic [3*STORE_W-1:0] push_sums;
    sbd_tag_t             push_tag;
    logic [Q_W-1:0]       q_rdata;
    sbd_tag_t             pop_tag;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FACTOR:     cfg_next.factor     = cfg_data[FACTOR_W-1:0];
                REG_OUT_WIDTH:  cfg_next.out_width  = cfg_data[WIDTH_W-1:0];
                REG_OUT_HEIGHT: cfg_next.out_height = cfg_data[WIDTH_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.factor     <= FACTOR_RST;
            cfg_reg.out_width  <= WIDTH_RST;
            cfg_reg.out_height <= HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbd_front #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_free   (q_free),
        .q_push   (push),
        .q_sums   (push_sums),
        .q_tag    (push_tag)
    );

    sbd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({push_sums, push_tag}),
        .pop   (pop),
        .rdata (q_rdata),
        .valid (q_valid),
        .free  (q_free)
    );

    assign pop_tag = q_rdata[$bits(sbd_tag_t)-1:0];

    sbd_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (pop),
        .q_sums   (q_rdata[Q_W-1:$bits(sbd_tag_t)]),
        .q_tag    (pop_tag),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
